@@ src/assert_macros.svh @@
// assertion macros used by the list control rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ src/pirl_pkg.sv @@
// types, codes and defaults for the positional insert / remove list
package pirl_pkg;

    localparam int CAPACITY   = 16;
    localparam int WORD_WIDTH = 32;

    localparam logic [1:0] K_INSERT     = 2'd0;
    localparam logic [1:0] K_REMOVE_AT  = 2'd1;
    localparam logic [1:0] K_REMOVE_VAL = 2'd2;
    localparam logic [1:0] K_READ_AT    = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  position;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  count;
        logic [31:0] read_value;
        logic [3:0]  where_found;
    } rsp_t;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic use_first;
    } cell_ctl_t;

endpackage

@@ src/pirl_cell.sv @@
// one list entry: holds a word, compares it, shifts with its neighbors
module pirl_cell
    import pirl_pkg::*;
#(
    parameter int CAPACITY   = pirl_pkg::CAPACITY,
    parameter int WORD_WIDTH = pirl_pkg::WORD_WIDTH,
    parameter int IDX        = 0
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_ctl_t                     ctl,
    input  logic [$clog2(CAPACITY)-1:0]   target,
    input  logic [$clog2(CAPACITY+1)-1:0] count,
    input  logic [WORD_WIDTH-1:0]         key,
    input  logic [WORD_WIDTH-1:0]         left_data,
    input  logic [WORD_WIDTH-1:0]         right_data,
    input  logic                          found_in,
    output logic [WORD_WIDTH-1:0]         data,
    output logic                          found_out,
    output logic                          sel
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

    logic [WORD_WIDTH-1:0] data_reg;
    logic [WORD_WIDTH-1:0] data_next;
    logic                  match_reg;
    logic                  match_next;
    logic                  above;

    // match flag is registered so the first-hit chain runs in the next cycle
    assign match_next = (MY_CNT < count) && (data_reg == key);

    always_comb
    begin
        if (ctl.use_first)
        begin
            sel   = match_reg && !found_in;
            above = match_reg || found_in;
        end
        else
        begin
            sel   = (target == MY_IDX);
            above = (MY_IDX >= target);
        end
    end

    assign found_out = found_in || match_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift_up)
        begin
            if (sel)
            begin
                data_next = key;
            end
            else if (above)
            begin
                data_next = left_data;
            end
        end
        else if (ctl.shift_down && above)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ src/pirl_ctrl.sv @@
// request sequencing, fill count and result register of the list
`include "assert_macros.svh"
module pirl_ctrl
    import pirl_pkg::*;
#(
    parameter int CAPACITY   = pirl_pkg::CAPACITY,
    parameter int WORD_WIDTH = pirl_pkg::WORD_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  req_t                          req,
    output logic                          busy,
    output logic                          done,
    output rsp_t                          rsp,
    output cell_ctl_t                     ctl,
    output logic [$clog2(CAPACITY)-1:0]   target,
    output logic [$clog2(CAPACITY+1)-1:0] count,
    output logic [WORD_WIDTH-1:0]         key,
    input  logic                          found,
    input  logic [WORD_WIDTH-1:0]         rd_word,
    input  logic [$clog2(CAPACITY)-1:0]   sel_idx
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    req_t             req_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             done_reg;
    logic             accept;
    logic             exec;
    logic             full;
    logic             in_range;
    logic             ok;
    logic [1:0]       st;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] ins_ext;

    assign busy   = (state_reg == S_MATCH);
    assign accept = start && !busy;
    assign exec   = (state_reg == S_EXEC);

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_MATCH : S_IDLE;
            S_MATCH: state_next = S_EXEC;
            S_EXEC:  state_next = accept ? S_MATCH : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign key      = WORD_WIDTH'(req_reg.value);
    assign pos_ext  = CMP_W'(req_reg.position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign in_range = (pos_ext < cnt_ext);
    // insert past the end appends
    assign ins_ext  = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;

    always_comb
    begin
        target         = IDX_W'(pos_ext);
        ok             = in_range;
        st             = in_range ? ST_DONE : ST_RANGE;
        ctl.shift_up   = 1'b0;
        ctl.shift_down = 1'b0;
        ctl.use_first  = 1'b0;
        case (req_reg.kind)
            K_INSERT:
            begin
                target       = IDX_W'(ins_ext);
                ok           = !full;
                st           = full ? ST_FULL : ST_DONE;
                ctl.shift_up = exec && !full;
            end
            K_REMOVE_AT:
            begin
                ctl.shift_down = exec && in_range;
            end
            K_REMOVE_VAL:
            begin
                ok             = found;
                st             = found ? ST_DONE : ST_NOTFOUND;
                ctl.use_first  = 1'b1;
                ctl.shift_down = exec && found;
            end
            K_READ_AT:
            begin
                ok = in_range;
            end
            default:
            begin
                ok = in_range;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.shift_up)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (ctl.shift_down)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_comb
    begin
        rsp_next.status      = st;
        rsp_next.count       = 5'(count_next);
        rsp_next.read_value  = (ok && (req_reg.kind != K_INSERT)) ? 32'(rd_word) : 32'd0;
        rsp_next.where_found = ok ? 4'(sel_idx) : 4'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done  = done_reg;
    assign rsp   = rsp_reg;
    assign count = count_reg;

    `ASSERT_PROP(a_done_lat, clk, rst_n, start && !busy |=> ##2 done, "result strobe missing after transfer")
    `ASSERT_PROP(a_ins_cnt, clk, rst_n, ctl.shift_up |=> count_reg == $past(count_reg) + 1'b1, "insert count wrong")
    `ASSERT_PROP(a_rem_cnt, clk, rst_n, ctl.shift_down |=> count_reg == $past(count_reg) - 1'b1, "remove count wrong")
    `ASSERT_PROP(a_fail_hold, clk, rst_n, exec && !ok |=> count_reg == $past(count_reg), "failed request changed count")
    `ASSERT_NEVER(a_cnt_cap, clk, rst_n, count_reg > CNT_W'(CAPACITY), "count above capacity")

endmodule

@@ src/positional_insert_remove_list_top.sv @@
// top level of the positional insert / remove list
//
// usage:
//   a request (req: kind, position, value) transfers at a rising edge where
//   start is high and busy is low. kinds: insert, remove at position, remove
//   first equal word, read at position.
//   every request gives exactly one result on rsp (status, count, read_value,
//   where_found), marked by done for one cycle; the receiver cannot stall it.
// done and rsp are registered at the end of the execute state, which follows the compare state.
// the compare state registers the per-cell compare against the stored words, the execute
//   state resolves the first hit along the cell chain (or the cell at the requested position),
//   shifts the row of cells and loads the result.
// busy is high only in the compare cycle, so the next request may transfer in
//   the same cycle the previous result is being committed.
// reset: fill count cleared, list empty; stored words are undefined until
//   written and are never read before that.
module positional_insert_remove_list_top
    import pirl_pkg::*;
#(
    parameter int CAPACITY   = pirl_pkg::CAPACITY,
    parameter int WORD_WIDTH = pirl_pkg::WORD_WIDTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_ctl_t             ctl;
    logic [IDX_W-1:0]      target;
    logic [CNT_W-1:0]      count;
    logic [WORD_WIDTH-1:0] key;
    logic [WORD_WIDTH-1:0] cell_data [CAPACITY];
    logic                  found_chain [CAPACITY+1];
    logic                  sel_vec [CAPACITY];
    logic [WORD_WIDTH-1:0] rd_word;
    logic [IDX_W-1:0]      sel_idx;

    assign found_chain[0] = 1'b0;

    pirl_ctrl #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .ctl     (ctl),
        .target  (target),
        .count   (count),
        .key     (key),
        .found   (found_chain[CAPACITY]),
        .rd_word (rd_word),
        .sel_idx (sel_idx)
    );

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [WORD_WIDTH-1:0] left_w;
        logic [WORD_WIDTH-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = key;
        end
        else
        begin : g_left
            assign left_w = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = cell_data[g];
        end
        else
        begin : g_right
            assign right_w = cell_data[g+1];
        end

        pirl_cell #(
            .CAPACITY   (CAPACITY),
            .WORD_WIDTH (WORD_WIDTH),
            .IDX        (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .target     (target),
            .count      (count),
            .key        (key),
            .left_data  (left_w),
            .right_data (right_w),
            .found_in   (found_chain[g]),
            .data       (cell_data[g]),
            .found_out  (found_chain[g+1]),
            .sel        (sel_vec[g])
        );
    end

    // selected cell drives the read word and its index
    always_comb
    begin
        rd_word = '0;
        sel_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (sel_vec[i])
            begin
                rd_word = rd_word | cell_data[i];
                sel_idx = sel_idx | IDX_W'(i);
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the positional insert / remove list top level
module testbench;
    import pirl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 530;
    localparam int REQ_W       = $bits(req_t);

    class list_tracker;
        logic [WORD_WIDTH-1:0] store [CAPACITY];
        int fill;
        rsp_t expected_rsp [$];
        int errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function logic [WORD_WIDTH-1:0] take_entry(int idx);
            logic [WORD_WIDTH-1:0] gone;
            gone = store[idx];
            for (int i = idx; i + 1 < fill; i++)
                store[i] = store[i + 1];
            fill--;
            return gone;
        endfunction

        function void note_request(req_t r);
            rsp_t e;
            int p;
            bit hit;
            e = '0;
            p = int'(r.position);
            hit = 0;
            case (r.kind)
                K_INSERT:
                begin
                    if (fill >= CAPACITY)
                        e.status = ST_FULL;
                    else
                    begin
                        if (p > fill)
                            p = fill;
                        for (int i = fill; i > p; i--)
                            store[i] = store[i - 1];
                        store[p] = r.value;
                        fill++;
                        e.where_found = p[3:0];
                    end
                end
                K_REMOVE_AT:
                begin
                    if (p >= fill)
                        e.status = ST_RANGE;
                    else
                    begin
                        e.read_value = take_entry(p);
                        e.where_found = p[3:0];
                    end
                end
                K_REMOVE_VAL:
                begin
                    e.status = ST_NOTFOUND;
                    for (int i = 0; i < fill && !hit; i++)
                    begin
                        if (store[i] == r.value)
                        begin
                            hit = 1;
                            e.read_value = take_entry(i);
                            e.where_found = i[3:0];
                            e.status = ST_DONE;
                        end
                    end
                end
                default:
                begin
                    if (p >= fill)
                        e.status = ST_RANGE;
                    else
                    begin
                        e.read_value = store[p];
                        e.where_found = p[3:0];
                    end
                end
            endcase
            e.count = fill[4:0];
            expected_rsp.push_back(e);
        endfunction

        task check_response(rsp_t got);
            rsp_t e;
            if (expected_rsp.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
                return;
            end
            e = expected_rsp.pop_front();
            if (got.status !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d", got.status, e.status));
            if (got.count !== e.count)
                report_mismatch($sformatf("count %0d, expected %0d", got.count, e.count));
            if (got.read_value !== e.read_value)
                report_mismatch($sformatf("read_value %h, expected %h",
                                          got.read_value, e.read_value));
            if (got.where_found !== e.where_found)
                report_mismatch($sformatf("where_found %0d, expected %0d",
                                          got.where_found, e.where_found));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;

    list_tracker trk = new();
    int cycles = 0;
    logic [31:0] pool [8];
    bit insert_heavy;
    int drift_left;

    positional_insert_remove_list_top u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("positional_insert_remove_list_top test failed");
            $finish;
        end
    end

    // results are checked before the same edge's transfer is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                trk.check_response(rsp);
            if (start && !busy)
                trk.note_request(req);
        end
    end

    task drive_item(req_t r);
        @(negedge clk);
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    task send(logic [1:0] kind, logic [7:0] position, logic [31:0] value);
        req_t r;
        r.kind = kind;
        r.position = position;
        r.value = value;
        drive_item(r);
    endtask

    task idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
            req <= REQ_W'({$urandom, $urandom});
        end
    endtask

    task wait_drained;
        @(negedge clk);
        start <= 1'b0;
        while (trk.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function req_t pick_request();
        req_t r;
        int roll;
        roll = $urandom_range(0, 99);
        if (insert_heavy)
            r.kind = roll < 55 ? K_INSERT : roll < 70 ? K_REMOVE_AT :
                     roll < 85 ? K_REMOVE_VAL : K_READ_AT;
        else
            r.kind = roll < 20 ? K_INSERT : roll < 50 ? K_REMOVE_AT :
                     roll < 75 ? K_REMOVE_VAL : K_READ_AT;
        if ($urandom_range(0, 99) < 85)
            r.position = 8'($urandom_range(0, trk.fill));
        else
            r.position = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (r.kind == K_REMOVE_VAL && trk.fill > 0 && roll < 70)
            r.value = trk.store[$urandom_range(0, trk.fill - 1)];
        else if (roll < 50)
            r.value = $urandom;
        else
            r.value = pool[$urandom_range(0, 7)];
        return r;
    endfunction

    task run_phase(int idle_pct);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (drift_left == 0)
            begin
                insert_heavy = ~insert_heavy;
                drift_left = $urandom_range(20, 60);
            end
            drift_left--;
            if ($urandom_range(0, 99) < idle_pct)
                idle_cycles($urandom_range(1, 3));
            drive_item(pick_request());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        insert_heavy = 1'b0;
        drift_left = 0;
        foreach (pool[i])
            pool[i] = $urandom;
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hffff_ffff;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list, duplicates, append, not found, fill to capacity, full and range errors
        send(K_READ_AT, 8'd0, 32'h0);
        send(K_REMOVE_AT, 8'd0, 32'h0);
        send(K_REMOVE_VAL, 8'd0, 32'h0);
        send(K_INSERT, 8'd255, 32'hffff_ffff);
        send(K_INSERT, 8'd0, 32'h0);
        send(K_INSERT, 8'd1, 32'h0);
        send(K_REMOVE_VAL, 8'd0, 32'h0);
        send(K_REMOVE_VAL, 8'd0, 32'h1234_5678);
        while (trk.fill < CAPACITY)
            send(K_INSERT, 8'($urandom_range(0, trk.fill + 1)), $urandom);
        send(K_INSERT, 8'd3, 32'haaaa_5555);
        send(K_READ_AT, 8'd15, 32'h0);
        send(K_READ_AT, 8'd16, 32'h0);
        send(K_REMOVE_AT, 8'd15, 32'h0);
        send(K_REMOVE_AT, 8'd255, 32'h0);
        send(K_READ_AT, 8'd255, 32'h0);
        send(K_REMOVE_AT, 8'd0, 32'h0);
        wait_drained();

        run_phase(37);
        wait_drained();
        run_phase(54);
        wait_drained();
        run_phase(0);
        wait_drained();

        if (trk.errors == 0)
            $display("positional_insert_remove_list_top test passed");
        else
            $display("positional_insert_remove_list_top test failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/pirl_pkg.sv
src/pirl_cell.sv
src/pirl_ctrl.sv
src/positional_insert_remove_list_top.sv
tb/testbench.sv
